// ===== design/hct_pkg.sv =====
package hct_pkg;

    localparam int KEY_W  = 16;
    localparam int MASK_W = 16;
    localparam int CB_W   = 16;
    localparam int REF_W  = 32;

    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic OP_SET    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
        logic [CB_W-1:0]   cb;
        logic [REF_W-1:0]  uref;
    } hct_entry_t;

endpackage

// ===== design/hct_entry_ram.sv =====
module hct_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  hct_pkg::hct_entry_t  wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output hct_pkg::hct_entry_t  rd_data
);

    hct_pkg::hct_entry_t entry_mem [DEPTH];
    hct_pkg::hct_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/handle_callback_table_top.sv =====
// channel   | ports                                               | handshake
// ----------+-----------------------------------------------------+---------------------------
// request   | operation handle_number event_mask callback_id      | start high while busy low
//           | user_ref                                            |
// result    | status slot entry_count                             | done strobe, one cycle
// config    | cfg_data (capacity)                                 | cfg_valid and cfg_ready
//
// a request takes its search over the entry ram, one slot per cycle through the single
// read port, stopping at the first slot whose key matches or after the last valid entry
// a remove that hits moves every later entry down one place, so the entries stay packed
// reset clears the count and restores capacity to 64; ram contents need no clearing
// the result strobe cannot be held off; busy drops in the cycle the strobe is shown
module handle_callback_table_top #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [hct_pkg::KEY_W-1:0]      handle_number,
    input  logic [hct_pkg::MASK_W-1:0]     event_mask,
    input  logic [hct_pkg::CB_W-1:0]       callback_id,
    input  logic [hct_pkg::REF_W-1:0]      user_ref,
    output logic                           done,
    output logic [hct_pkg::STATUS_W-1:0]   status,
    output logic [hct_pkg::SLOT_W-1:0]     slot,
    output logic [hct_pkg::COUNT_W-1:0]    entry_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hct_pkg::CAP_W-1:0]      cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = CW + 1;
    localparam int LW = (CW > hct_pkg::CAP_W) ? CW : hct_pkg::CAP_W;
    localparam int SW = (AW > hct_pkg::SLOT_W) ? AW : hct_pkg::SLOT_W;
    localparam int EW = (CW > hct_pkg::COUNT_W) ? CW : hct_pkg::COUNT_W;
    localparam logic [PW-1:0] MAX_P = PW'(MAX_ENTRIES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [hct_pkg::CAP_W-1:0]     cap_reg;
    logic                          done_reg, done_next;
    logic [hct_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [hct_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [hct_pkg::COUNT_W-1:0]   ecount_reg, ecount_next;

    logic                          op_reg;
    logic [hct_pkg::KEY_W-1:0]     key_reg;
    logic [hct_pkg::MASK_W-1:0]    mask_reg;
    logic [hct_pkg::CB_W-1:0]      cb_reg;
    logic [hct_pkg::REF_W-1:0]     uref_reg;

    logic                          accept;
    logic                          rd_en, wr_en;
    logic [AW-1:0]                 rd_addr, wr_addr;
    hct_pkg::hct_entry_t           wr_data, rd_data;

    logic [PW-1:0]                 idx_p, idx_p1, count_p;
    logic                          hit, room;
    logic [AW-1:0]                 slot_idx;
    logic [SW-1:0]                 slot_wide;
    logic [EW-1:0]                 ecount_wide;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign idx_p   = PW'(idx_reg);
    assign idx_p1  = PW'(idx_reg) + PW'(1);
    assign count_p = PW'(count_reg);
    assign hit     = (idx_p < count_p) && (rd_data.key == key_reg);
    // room only while below both the programmed capacity and the ram depth
    assign room    = (LW'(count_reg) < LW'(cap_reg)) && (count_p < MAX_P);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_idx    = '0;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = '{key: key_reg, mask: mask_reg, cb: cb_reg, uref: uref_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    pos_next = idx_reg;
                    slot_idx = idx_reg;
                    if (op_reg == hct_pkg::OP_SET)
                    begin
                        wr_en       = 1'b1;
                        done_next   = 1'b1;
                        status_next = hct_pkg::ST_UPDATED;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        if (idx_p1 < count_p)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(idx_p1);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = hct_pkg::ST_REMOVED;
                            state_next  = S_IDLE;
                        end
                    end
                end
                else if (idx_p1 < count_p)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_p1);
                    idx_next = AW'(idx_p1);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == hct_pkg::OP_SET)
                    begin
                        if (room)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = AW'(count_reg);
                            slot_idx    = AW'(count_reg);
                            count_next  = count_reg + CW'(1);
                            status_next = hct_pkg::ST_ADDED;
                        end
                        else
                        begin
                            status_next = hct_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        status_next = hct_pkg::ST_NOT_FOUND;
                    end
                end
            end

            S_SHIFT:
            begin
                // rd_data holds slot idx+1, move it down one place
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                // count already holds the reduced value here
                if (idx_p1 < count_p)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_p1 + PW'(1));
                    idx_next = AW'(idx_p1);
                end
                else
                begin
                    slot_idx    = pos_reg;
                    done_next   = 1'b1;
                    status_next = hct_pkg::ST_REMOVED;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign slot_wide   = SW'(slot_idx);
    assign slot_next   = (done_next && (status_next != hct_pkg::ST_FULL)
                          && (status_next != hct_pkg::ST_NOT_FOUND))
                         ? slot_wide[hct_pkg::SLOT_W-1:0] : '0;
    assign ecount_wide = EW'(count_next);
    assign ecount_next = ecount_wide[hct_pkg::COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cap_reg    <= hct_pkg::CAP_RESET;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            key_reg  <= handle_number;
            mask_reg <= event_mask;
            cb_reg   <= callback_id;
            uref_reg <= user_ref;
        end
        if (done_next)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            ecount_reg <= ecount_next;
        end
    end

    hct_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign entry_count = ecount_reg;

endmodule

// ===== test/tb_handle_callback_table_top.sv =====
module tb_handle_callback_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hct_pkg::*;

    localparam int MAX_ENTRIES  = 64;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 165;
    localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } reply_t;

    class registration_scoreboard;
        hct_entry_t  entries [MAX_ENTRIES];
        int unsigned valid_count;
        int unsigned room;
        reply_t      pending_replies [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned status_seen [8];

        function new();
            valid_count = 0;
            room        = MAX_ENTRIES;
            errors      = 0;
            checked     = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            room = (cap > MAX_ENTRIES) ? MAX_ENTRIES : cap;
        endfunction

        function void flag(string msg);
            if (errors < 10) $display("%0t mismatch: %s", $time, msg);
            errors++;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] key, logic [MASK_W-1:0] mask,
                                   logic [CB_W-1:0] cb, logic [REF_W-1:0] uref);
            reply_t      r;
            int unsigned pos;
            pos = valid_count;
            for (int unsigned i = 0; i < valid_count; i++) begin
                if (entries[i].key == key) begin
                    pos = i;
                    break;
                end
            end
            r.slot = '0;
            if (op == OP_SET) begin
                if (pos < valid_count) begin
                    entries[pos].mask = mask;
                    entries[pos].cb   = cb;
                    entries[pos].uref = uref;
                    r.status = ST_UPDATED;
                    r.slot   = pos[SLOT_W-1:0];
                end else if (valid_count < room) begin
                    entries[valid_count] = '{key: key, mask: mask, cb: cb, uref: uref};
                    r.status = ST_ADDED;
                    r.slot   = valid_count[SLOT_W-1:0];
                    valid_count++;
                end else begin
                    r.status = ST_FULL;
                end
            end else begin
                if (pos < valid_count) begin
                    valid_count--;
                    // close the gap so entries stay packed from slot 0
                    for (int unsigned j = pos; j < valid_count; j++)
                        entries[j] = entries[j + 1];
                    r.status = ST_REMOVED;
                    r.slot   = pos[SLOT_W-1:0];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            r.count = valid_count[COUNT_W-1:0];
            pending_replies.push_back(r);
        endfunction

        function void check_result(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                flag($sformatf("result with no request outstanding: status %0d slot %0d count %0d",
                               got.status, got.slot, got.count));
                return;
            end
            want = pending_replies.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status || got.slot !== want.slot
                || got.count !== want.count)
                flag($sformatf("expected status %0d slot %0d count %0d, got %0d %0d %0d",
                               want.status, want.slot, want.count,
                               got.status, got.slot, got.count));
        endfunction

        function int unsigned pending();
            return pending_replies.size();
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    logic                operation     = OP_SET;
    logic [KEY_W-1:0]    handle_number = '0;
    logic [MASK_W-1:0]   event_mask    = '0;
    logic [CB_W-1:0]     callback_id   = '0;
    logic [REF_W-1:0]    user_ref      = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  entry_count;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data      = '0;

    registration_scoreboard sb = new();
    bit gaps_on = 1'b1;

    handle_callback_table_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .handle_number (handle_number),
        .event_mask    (event_mask),
        .callback_id   (callback_id),
        .user_ref      (user_ref),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .entry_count   (entry_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{status: status, slot: slot, count: entry_count});
    end

    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [MASK_W-1:0] mask, input logic [CB_W-1:0] cb,
                                input logic [REF_W-1:0] uref);
        int unsigned gap;
        int unsigned roll;
        start         <= 1'b1;
        operation     <= op;
        handle_number <= key;
        event_mask    <= mask;
        callback_id   <= cb;
        user_ref      <= uref;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(op, key, mask, cb, uref);
        gap = 0;
        if (gaps_on) begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)
                gap = $urandom_range(8, 40);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        // with no gap start simply stays high for the next request
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_capacity(cap);
    endtask

    initial
    begin
        int               phase_cap [PHASES];
        int               phase_set_pct [PHASES];
        int               phase_pool [PHASES];
        logic [KEY_W-1:0] pool [80];
        logic [KEY_W-1:0] key;
        logic             op;

        phase_cap     = '{127, 64, 1, 0, 7, 64, 40, 2, 65, 64};
        phase_set_pct = '{90, 55, 60, 60, 65, 80, 50, 60, 85, 45};
        phase_pool    = '{80, 72, 8, 8, 16, 70, 48, 6, 78, 30};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, field extremes, update in place, removal with shift
        send_request(OP_REMOVE, 16'h1234, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_SET, 16'h0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_SET, 16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0000);
        send_request(OP_SET, 16'h00FF, 16'hA5A5, 16'h5A5A, 32'hDEAD_BEEF);
        send_request(OP_SET, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        send_request(OP_REMOVE, 16'h0000, 16'h1357, 16'h2468, 32'h1234_5678);
        send_request(OP_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 16'h1234, 16'h0000, 16'h0000, 32'h0000_0000);
        wait_idle();

        // small capacity: full, then room again after a removal
        write_capacity(7'd2);
        send_request(OP_SET, 16'hAAAA, 16'h0001, 16'h0002, 32'h0000_0003);
        send_request(OP_REMOVE, 16'h00FF, 16'h0000, 16'h0000, 32'h0000_0000);
        send_request(OP_SET, 16'hAAAA, 16'h0001, 16'h0002, 32'h0000_0003);
        wait_idle();

        // capacity lowered below the current count
        write_capacity(7'd1);
        send_request(OP_SET, 16'h5555, 16'h8000, 16'h8000, 32'h8000_0000);
        send_request(OP_SET, 16'hAAAA, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF);
        send_request(OP_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0000);
        send_request(OP_SET, 16'h5555, 16'h8000, 16'h8000, 32'h8000_0000);
        wait_idle();

        // zero capacity never admits a new handle
        write_capacity(7'd0);
        send_request(OP_SET, 16'h1111, 16'h0F0F, 16'hF0F0, 32'h0F0F_0F0F);
        send_request(OP_SET, 16'hAAAA, 16'hF0F0, 16'h0F0F, 32'hF0F0_F0F0);
        send_request(OP_REMOVE, 16'hAAAA, 16'h0000, 16'h0000, 32'h0000_0000);
        send_request(OP_SET, 16'hAAAA, 16'h0000, 16'h0000, 32'h0000_0000);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_cap[p][CAP_W-1:0]);
            gaps_on = ($urandom_range(0, 3) != 0);
            foreach (pool[i]) pool[i] = 16'($urandom);
            pool[0] = 16'h0000;
            pool[1] = 16'hFFFF;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 99) < phase_set_pct[p]) ? OP_SET : OP_REMOVE;
                if ($urandom_range(0, 99) < 85)
                    key = pool[$urandom_range(0, phase_pool[p] - 1)];
                else
                    key = 16'($urandom);
                send_request(op, key, 16'($urandom), 16'($urandom), $urandom);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results over %0d capacity phases: added %0d updated %0d",
                 sb.checked, PHASES + 4, sb.status_seen[ST_ADDED], sb.status_seen[ST_UPDATED]);
        $display("full %0d removed %0d not found %0d, mismatches %0d",
                 sb.status_seen[ST_FULL], sb.status_seen[ST_REMOVED],
                 sb.status_seen[ST_NOT_FOUND], sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[handle_callback_table_top] OK");
        else
            $display("[handle_callback_table_top] ERROR");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("[handle_callback_table_top] ERROR");
        $finish;
    end

endmodule
